FILE: design/best_fit_range_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the best-fit range allocator
// Concurrent checks that compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_RANGE_ALLOCATOR_CORE_MACROS_SVH
`define BEST_FIT_RANGE_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BRFA_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brfa: check failed");
`define BRFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brfa: check failed");
`else
`define BRFA_ASSERT_IMPLIES(lbl, ante, cons)
`define BRFA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: design/brfa_pkg.sv
// ----------------------------------------------------------------------------
// brfa_pkg
// Shared widths, codes and types of the best-fit range allocator.
// ----------------------------------------------------------------------------
package brfa_pkg;

    localparam int MAX_SLOTS    = 1024;
    localparam int MAX_RANGES   = 512;
    localparam int STALE_DEPTH  = 64;

    localparam int SLOT_W       = 10;
    localparam int LEN_W        = 11;
    localparam int HEAP_W       = 11;
    localparam int ADDR_W       = 48;
    localparam int STRIDE_W     = 13;
    localparam int PROD_W       = SLOT_W + STRIDE_W;
    localparam int DIV_CNT_W    = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 48;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;

    localparam int RESET_HEAP   = 1024;
    localparam int RESET_STRIDE = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NO_SPACE   = 2'd1,
        STATUS_QUEUE_FULL = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEAP_SIZE    = 2'd0,
        REG_BASE_ADDRESS = 2'd1,
        REG_SLOT_STRIDE  = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALLOC_SCAN,
        ST_ALLOC_APPLY,
        ST_GRANT_MUL,
        ST_GRANT_ADD,
        ST_FREE_DIV,
        ST_REL_READ,
        ST_REL_SCAN,
        ST_REL_DECIDE,
        ST_REL_APPLY
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } range_entry_t;

    typedef struct packed {
        logic [SLOT_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } stale_entry_t;

    typedef struct packed {
        logic shift;
        logic init;
    } cell_ctl_t;

    localparam range_entry_t EMPTY_ENTRY = '0;
    localparam range_entry_t HEAD_RESET_ENTRY =
        '{valid: 1'b1, start: '0, len: LEN_W'(RESET_HEAP)};

    function automatic logic [HEAP_W-1:0] sat_heap(input logic [HEAP_W-1:0] v);
        logic [HEAP_W-1:0] r;
        r = v;
        if (v == '0)
            r = HEAP_W'(1);
        else if (v > HEAP_W'(MAX_SLOTS))
            r = HEAP_W'(MAX_SLOTS);
        return r;
    endfunction

endpackage

FILE: design/brfa_cell.sv
// ----------------------------------------------------------------------------
// brfa_cell
// One free-range table entry; passes its entry to the neighbor on shift.
// ----------------------------------------------------------------------------
module brfa_cell #(
    parameter brfa_pkg::range_entry_t RST_ENTRY = brfa_pkg::EMPTY_ENTRY
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  brfa_pkg::cell_ctl_t    ctl,
    input  brfa_pkg::range_entry_t init_entry,
    input  brfa_pkg::range_entry_t in_entry,
    output brfa_pkg::range_entry_t out_entry
);

    brfa_pkg::range_entry_t entry_reg;
    brfa_pkg::range_entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.init)
            entry_next = init_entry;
        else if (ctl.shift)
            entry_next = in_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= RST_ENTRY;
        else
            entry_reg <= entry_next;
    end

    assign out_entry = entry_reg;

endmodule

FILE: design/brfa_div.sv
// ----------------------------------------------------------------------------
// brfa_div
// Restoring divider, one quotient bit per cycle (address offset / stride).
// ----------------------------------------------------------------------------
module brfa_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [brfa_pkg::ADDR_W-1:0]   dividend,
    input  logic [brfa_pkg::STRIDE_W-1:0] divisor,
    output logic [brfa_pkg::ADDR_W-1:0]   quotient,
    output logic                          done
);

    localparam int AW = brfa_pkg::ADDR_W;
    localparam int SW = brfa_pkg::STRIDE_W;
    localparam int CW = brfa_pkg::DIV_CNT_W;

    logic [SW-1:0] rem_reg, rem_next;
    logic [AW-1:0] quo_reg, quo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [SW:0]   trial;
    logic          ge;

    assign trial = {rem_reg, quo_reg[AW-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? SW'(trial - {1'b0, divisor}) : trial[SW-1:0];
            quo_next = {quo_reg[AW-2:0], ge};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(AW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

FILE: design/brfa_stale_fifo.sv
// ----------------------------------------------------------------------------
// brfa_stale_fifo
// Storage of freed ranges waiting for release; registered read port.
// ----------------------------------------------------------------------------
module brfa_stale_fifo #(
    parameter int DEPTH = brfa_pkg::STALE_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  brfa_pkg::stale_entry_t wr_data,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    output brfa_pkg::stale_entry_t rd_data
);

    brfa_pkg::stale_entry_t mem [DEPTH];
    brfa_pkg::stale_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/best_fit_range_allocator_core.sv
// ----------------------------------------------------------------------------
// best_fit_range_allocator_core
// Best-fit slot allocator with a stale-free queue and coalescing release.
// ----------------------------------------------------------------------------
// One request at a time: busy is high while a request is in work, and the
// result appears for one cycle with done; the receiver cannot stall it. The
// free-range table is a ring of MAX_RANGES cells that rotates one place per
// cycle during a table pass, past a single compare/update head. Allocate:
// search pass, update pass, multiply, add; it ends after the search pass when
// no range fits, and is rejected up front when the count is zero or above the
// free total. Free: 48-step divider plus queueing, rejected up front when the
// queue is full. Release: per stale entry a read, a scan pass, a decision and
// an update pass, which a dropped entry skips; it ends in idle if the queue is empty.
// Configuration writes are taken only while busy is low.
// ----------------------------------------------------------------------------
`include "best_fit_range_allocator_core_macros.svh"

module best_fit_range_allocator_core #(
    parameter int MAX_RANGES  = brfa_pkg::MAX_RANGES,
    parameter int STALE_DEPTH = brfa_pkg::STALE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [brfa_pkg::OP_W-1:0]       operation,
    input  logic [brfa_pkg::LEN_W-1:0]      request_count,
    input  logic [brfa_pkg::ADDR_W-1:0]     handle_address,
    output logic                            done,
    output logic [brfa_pkg::STATUS_W-1:0]   status,
    output logic [brfa_pkg::SLOT_W-1:0]     start_slot,
    output logic [brfa_pkg::ADDR_W-1:0]     grant_address,
    output logic [brfa_pkg::LEN_W-1:0]      free_total,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [brfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [brfa_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int SW     = brfa_pkg::SLOT_W;
    localparam int LW     = brfa_pkg::LEN_W;
    localparam int HW     = brfa_pkg::HEAP_W;
    localparam int AW     = brfa_pkg::ADDR_W;
    localparam int TW     = brfa_pkg::STRIDE_W;
    localparam int PW     = brfa_pkg::PROD_W;
    localparam int PASS_W = $clog2(MAX_RANGES + 1);
    localparam int FILL_W = $clog2(STALE_DEPTH + 1);
    localparam int QAW    = (STALE_DEPTH > 1) ? $clog2(STALE_DEPTH) : 1;

    brfa_pkg::state_t state_reg, state_next;

    logic [PASS_W-1:0] cnt_reg, cnt_next;
    logic [LW-1:0]     n_reg, n_next;
    logic              best_found_reg, best_found_next;
    logic [SW-1:0]     best_start_reg, best_start_next;
    logic [LW-1:0]     best_len_reg, best_len_next;
    logic              pred_found_reg, pred_found_next;
    logic [SW-1:0]     pred_start_reg, pred_start_next;
    logic [LW-1:0]     pred_len_reg, pred_len_next;
    logic              succ_found_reg, succ_found_next;
    logic [SW-1:0]     succ_start_reg, succ_start_next;
    logic [LW-1:0]     succ_len_reg, succ_len_next;
    logic              spare_reg, spare_next;
    logic              pj_reg, pj_next;
    logic              nj_reg, nj_next;
    logic              placed_reg, placed_next;
    logic [SW-1:0]     mrg_start_reg, mrg_start_next;
    logic [LW-1:0]     mrg_len_reg, mrg_len_next;
    logic [FILL_W-1:0] k_reg, k_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [LW-1:0]     free_count_reg, free_count_next;
    logic [HW-1:0]     heap_reg, heap_next;
    logic [AW-1:0]     base_reg, base_next;
    logic [TW-1:0]     stride_reg, stride_next;
    logic [PW-1:0]     prod_reg, prod_next;
    logic              done_reg, done_next;
    brfa_pkg::status_t status_reg, status_next;
    logic [SW-1:0]     start_slot_reg, start_slot_next;
    logic [AW-1:0]     grant_reg, grant_next;

    brfa_pkg::cell_ctl_t    cell_ctl;
    brfa_pkg::range_entry_t head_init;
    brfa_pkg::range_entry_t head;
    brfa_pkg::range_entry_t wb;
    brfa_pkg::range_entry_t cell_out [MAX_RANGES];

    logic                   q_wr_en, q_rd_en;
    brfa_pkg::stale_entry_t q_wr_data, q_rd_data;

    logic          div_go, div_done;
    logic [AW-1:0] div_q;

    logic          accept;
    logic [TW-1:0] stride_eff;
    logic [HW-1:0] cfg_heap;
    logic          alloc_reject, queue_full, queue_empty, pass_last, k_last;
    logic          best_take, best_found_after;
    logic          in_pool;
    logic [SW+1:0] q_end;
    logic [SW:0]   pred_end, rel_end;
    logic          ovp, ovn, pj, nj, rel_drop;
    logic [FILL_W-1:0] k_inc;

    // ------------------------------------------------------------------
    // cell ring: cell 0 is the head, the last cell takes the head write-back
    // ------------------------------------------------------------------
    assign head = cell_out[0];

    for (genvar i = 0; i < MAX_RANGES; i++)
    begin : g_cell
        brfa_pkg::range_entry_t cell_in;
        if (i == MAX_RANGES - 1)
        begin : g_tail
            assign cell_in = wb;
        end
        else
        begin : g_body
            assign cell_in = cell_out[i + 1];
        end
        brfa_cell #(
            .RST_ENTRY ((i == 0) ? brfa_pkg::HEAD_RESET_ENTRY : brfa_pkg::EMPTY_ENTRY)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (cell_ctl),
            .init_entry ((i == 0) ? head_init : brfa_pkg::EMPTY_ENTRY),
            .in_entry   (cell_in),
            .out_entry  (cell_out[i])
        );
    end

    brfa_stale_fifo #(
        .DEPTH (STALE_DEPTH),
        .AW    (QAW)
    ) u_stale_fifo (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_addr (fill_reg[QAW-1:0]),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_addr (k_reg[QAW-1:0]),
        .rd_data (q_rd_data)
    );

    brfa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (handle_address - base_reg),
        .divisor  (stride_eff),
        .quotient (div_q),
        .done     (div_done)
    );

    // ------------------------------------------------------------------
    // shared decode
    // ------------------------------------------------------------------
    assign busy         = (state_reg != brfa_pkg::ST_IDLE);
    assign cfg_ready    = !busy;
    assign accept       = start && !busy;
    assign stride_eff   = (stride_reg == '0) ? TW'(1) : stride_reg;
    assign cfg_heap     = brfa_pkg::sat_heap(cfg_data[HW-1:0]);
    assign head_init    = '{valid: 1'b1, start: '0, len: LW'(cfg_heap)};
    assign alloc_reject = (request_count == '0) || (request_count > free_count_reg);
    assign queue_full   = (fill_reg >= FILL_W'(STALE_DEPTH));
    assign queue_empty  = (fill_reg == '0);
    assign pass_last    = (cnt_reg == PASS_W'(MAX_RANGES - 1));
    assign k_inc        = k_reg + FILL_W'(1);
    assign k_last       = (k_inc == fill_reg);

    assign best_take = head.valid && (head.len >= n_reg) &&
                       (!best_found_reg || (head.len < best_len_reg) ||
                        ((head.len == best_len_reg) && (head.start < best_start_reg)));
    assign best_found_after = best_found_reg || best_take;

    // slot plus count can reach 1023 + 2047, one bit more than a length
    assign q_end   = (SW+2)'(div_q[SW-1:0]) + (SW+2)'(n_reg);
    assign in_pool = (n_reg != '0) && (div_q < AW'(heap_reg)) && (q_end <= (SW+2)'(heap_reg));

    assign pred_end = (SW+1)'(pred_start_reg) + (SW+1)'(pred_len_reg);
    assign rel_end  = (SW+1)'(q_rd_data.start) + (SW+1)'(q_rd_data.len);
    assign ovp      = pred_found_reg && (pred_end > (SW+1)'(q_rd_data.start));
    assign ovn      = succ_found_reg && (rel_end > (SW+1)'(succ_start_reg));
    assign pj       = pred_found_reg && (pred_end == (SW+1)'(q_rd_data.start));
    assign nj       = succ_found_reg && (rel_end == (SW+1)'(succ_start_reg));
    assign rel_drop = ovp || ovn || (!pj && !nj && !spare_reg);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brfa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        brfa_pkg::OP_ALLOC:
                            if (!alloc_reject)
                                state_next = brfa_pkg::ST_ALLOC_SCAN;
                        brfa_pkg::OP_FREE:
                            if (!queue_full)
                                state_next = brfa_pkg::ST_FREE_DIV;
                        brfa_pkg::OP_RELEASE:
                            if (!queue_empty)
                                state_next = brfa_pkg::ST_REL_READ;
                        default:
                            state_next = brfa_pkg::ST_IDLE;
                    endcase
                end
            end
            brfa_pkg::ST_ALLOC_SCAN:
                if (pass_last)
                    state_next = best_found_after ? brfa_pkg::ST_ALLOC_APPLY
                                                  : brfa_pkg::ST_IDLE;
            brfa_pkg::ST_ALLOC_APPLY:
                if (pass_last)
                    state_next = brfa_pkg::ST_GRANT_MUL;
            brfa_pkg::ST_GRANT_MUL:
                state_next = brfa_pkg::ST_GRANT_ADD;
            brfa_pkg::ST_GRANT_ADD:
                state_next = brfa_pkg::ST_IDLE;
            brfa_pkg::ST_FREE_DIV:
                if (div_done)
                    state_next = brfa_pkg::ST_IDLE;
            brfa_pkg::ST_REL_READ:
                state_next = brfa_pkg::ST_REL_SCAN;
            brfa_pkg::ST_REL_SCAN:
                if (pass_last)
                    state_next = brfa_pkg::ST_REL_DECIDE;
            brfa_pkg::ST_REL_DECIDE:
                if (!rel_drop)
                    state_next = brfa_pkg::ST_REL_APPLY;
                else
                    state_next = k_last ? brfa_pkg::ST_IDLE : brfa_pkg::ST_REL_READ;
            brfa_pkg::ST_REL_APPLY:
                if (pass_last)
                    state_next = k_last ? brfa_pkg::ST_IDLE : brfa_pkg::ST_REL_READ;
            default:
                state_next = brfa_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        cnt_next        = cnt_reg;
        n_next          = n_reg;
        best_found_next = best_found_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        pred_found_next = pred_found_reg;
        pred_start_next = pred_start_reg;
        pred_len_next   = pred_len_reg;
        succ_found_next = succ_found_reg;
        succ_start_next = succ_start_reg;
        succ_len_next   = succ_len_reg;
        spare_next      = spare_reg;
        pj_next         = pj_reg;
        nj_next         = nj_reg;
        placed_next     = placed_reg;
        mrg_start_next  = mrg_start_reg;
        mrg_len_next    = mrg_len_reg;
        k_next          = k_reg;
        fill_next       = fill_reg;
        free_count_next = free_count_reg;
        heap_next       = heap_reg;
        base_next       = base_reg;
        stride_next     = stride_reg;
        prod_next       = prod_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        start_slot_next = start_slot_reg;
        grant_next      = grant_reg;
        cell_ctl        = '0;
        wb              = head;
        q_wr_en         = 1'b0;
        q_rd_en         = 1'b0;
        q_wr_data       = '{start: div_q[SW-1:0], len: n_reg};
        div_go          = 1'b0;

        case (state_reg)
            brfa_pkg::ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    case (cfg_index)
                        brfa_pkg::REG_HEAP_SIZE:
                        begin
                            heap_next       = cfg_heap;
                            free_count_next = LW'(cfg_heap);
                            fill_next       = '0;
                            cell_ctl.init   = 1'b1;
                        end
                        brfa_pkg::REG_BASE_ADDRESS:
                            base_next = cfg_data[AW-1:0];
                        brfa_pkg::REG_SLOT_STRIDE:
                            stride_next = cfg_data[TW-1:0];
                        default:
                            base_next = base_reg;
                    endcase
                end
                if (accept)
                begin
                    n_next          = request_count;
                    cnt_next        = '0;
                    best_found_next = 1'b0;
                    k_next          = '0;
                    start_slot_next = '0;
                    grant_next      = '0;
                    status_next     = brfa_pkg::STATUS_OK;
                    case (operation)
                        brfa_pkg::OP_ALLOC:
                            if (alloc_reject)
                            begin
                                done_next   = 1'b1;
                                status_next = brfa_pkg::STATUS_NO_SPACE;
                            end
                        brfa_pkg::OP_FREE:
                            if (queue_full)
                            begin
                                done_next   = 1'b1;
                                status_next = brfa_pkg::STATUS_QUEUE_FULL;
                            end
                            else
                                div_go = 1'b1;
                        brfa_pkg::OP_RELEASE:
                            done_next = queue_empty;
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end

            brfa_pkg::ST_ALLOC_SCAN:
            begin
                cell_ctl.shift = 1'b1;
                cnt_next       = pass_last ? '0 : cnt_reg + PASS_W'(1);
                if (best_take)
                begin
                    best_found_next = 1'b1;
                    best_start_next = head.start;
                    best_len_next   = head.len;
                end
                if (pass_last && !best_found_after)
                begin
                    done_next   = 1'b1;
                    status_next = brfa_pkg::STATUS_NO_SPACE;
                end
            end

            brfa_pkg::ST_ALLOC_APPLY:
            begin
                cell_ctl.shift = 1'b1;
                cnt_next       = pass_last ? '0 : cnt_reg + PASS_W'(1);
                if (head.valid && (head.start == best_start_reg))
                begin
                    if (best_len_reg > n_reg)
                    begin
                        wb.start = SW'(LW'(head.start) + n_reg);
                        wb.len   = head.len - n_reg;
                    end
                    else
                        wb.valid = 1'b0;
                end
                if (pass_last)
                    free_count_next = free_count_reg - n_reg;
            end

            brfa_pkg::ST_GRANT_MUL:
                prod_next = PW'(best_start_reg) * PW'(stride_eff);

            brfa_pkg::ST_GRANT_ADD:
            begin
                done_next       = 1'b1;
                start_slot_next = best_start_reg;
                grant_next      = base_reg + AW'(prod_reg);
            end

            brfa_pkg::ST_FREE_DIV:
            begin
                if (div_done)
                begin
                    done_next = 1'b1;
                    if (in_pool)
                    begin
                        q_wr_en   = 1'b1;
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end

            brfa_pkg::ST_REL_READ:
            begin
                q_rd_en         = 1'b1;
                cnt_next        = '0;
                pred_found_next = 1'b0;
                succ_found_next = 1'b0;
                spare_next      = 1'b0;
            end

            brfa_pkg::ST_REL_SCAN:
            begin
                cell_ctl.shift = 1'b1;
                cnt_next       = pass_last ? '0 : cnt_reg + PASS_W'(1);
                if (!head.valid)
                    spare_next = 1'b1;
                else if (head.start <= q_rd_data.start)
                begin
                    if (!pred_found_reg || (head.start > pred_start_reg))
                    begin
                        pred_found_next = 1'b1;
                        pred_start_next = head.start;
                        pred_len_next   = head.len;
                    end
                end
                else if (!succ_found_reg || (head.start < succ_start_reg))
                begin
                    succ_found_next = 1'b1;
                    succ_start_next = head.start;
                    succ_len_next   = head.len;
                end
            end

            brfa_pkg::ST_REL_DECIDE:
            begin
                cnt_next = '0;
                if (!rel_drop)
                begin
                    free_count_next = free_count_reg + q_rd_data.len;
                    pj_next         = pj;
                    nj_next         = nj;
                    placed_next     = 1'b0;
                    mrg_start_next  = pj ? pred_start_reg : q_rd_data.start;
                    mrg_len_next    = q_rd_data.len + (pj ? pred_len_reg : '0) +
                                      (nj ? succ_len_reg : '0);
                end
                else
                begin
                    k_next = k_inc;
                    if (k_last)
                    begin
                        fill_next = '0;
                        done_next = 1'b1;
                    end
                end
            end

            brfa_pkg::ST_REL_APPLY:
            begin
                cell_ctl.shift = 1'b1;
                cnt_next       = pass_last ? '0 : cnt_reg + PASS_W'(1);
                if (pj_reg && head.valid && (head.start == pred_start_reg))
                    wb = '{valid: 1'b1, start: mrg_start_reg, len: mrg_len_reg};
                else if (nj_reg && head.valid && (head.start == succ_start_reg))
                begin
                    // without a left merge the right neighbor's entry takes the result
                    if (!pj_reg)
                        wb = '{valid: 1'b1, start: mrg_start_reg, len: mrg_len_reg};
                    else
                        wb.valid = 1'b0;
                end
                else if (!pj_reg && !nj_reg && !head.valid && !placed_reg)
                begin
                    wb          = '{valid: 1'b1, start: mrg_start_reg, len: mrg_len_reg};
                    placed_next = 1'b1;
                end
                if (pass_last)
                begin
                    k_next = k_inc;
                    if (k_last)
                    begin
                        fill_next = '0;
                        done_next = 1'b1;
                    end
                end
            end

            default:
                cnt_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= brfa_pkg::ST_IDLE;
            cnt_reg        <= '0;
            fill_reg       <= '0;
            k_reg          <= '0;
            free_count_reg <= LW'(brfa_pkg::RESET_HEAP);
            heap_reg       <= HW'(brfa_pkg::RESET_HEAP);
            base_reg       <= '0;
            stride_reg     <= TW'(brfa_pkg::RESET_STRIDE);
            done_reg       <= 1'b0;
            status_reg     <= brfa_pkg::STATUS_OK;
            start_slot_reg <= '0;
            grant_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            fill_reg       <= fill_next;
            k_reg          <= k_next;
            free_count_reg <= free_count_next;
            heap_reg       <= heap_next;
            base_reg       <= base_next;
            stride_reg     <= stride_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
            start_slot_reg <= start_slot_next;
            grant_reg      <= grant_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        best_found_reg <= best_found_next;
        best_start_reg <= best_start_next;
        best_len_reg   <= best_len_next;
        pred_found_reg <= pred_found_next;
        pred_start_reg <= pred_start_next;
        pred_len_reg   <= pred_len_next;
        succ_found_reg <= succ_found_next;
        succ_start_reg <= succ_start_next;
        succ_len_reg   <= succ_len_next;
        spare_reg      <= spare_next;
        pj_reg         <= pj_next;
        nj_reg         <= nj_next;
        placed_reg     <= placed_next;
        mrg_start_reg  <= mrg_start_next;
        mrg_len_reg    <= mrg_len_next;
        prod_reg       <= prod_next;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign start_slot    = start_slot_reg;
    assign grant_address = grant_reg;
    assign free_total    = free_count_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `BRFA_ASSERT_IMPLIES(a_done_idle, done_reg, !busy)
    `BRFA_ASSERT_NEXT(a_accept_moves, accept, busy || done_reg)
    `BRFA_ASSERT_IMPLIES(a_fill_bound, 1'b1, fill_reg <= FILL_W'(STALE_DEPTH))
    `BRFA_ASSERT_IMPLIES(a_free_le_heap, 1'b1, free_count_reg <= LW'(heap_reg))

endmodule
